// ----- sv/gmd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_pkg: shared types and constants for the gradient magnitude/direction
// Holds the field widths, the direction codes, the sideband word that rides
// along the root pipeline, and the two-bit square root digit step.
// ----------------------------------------------------------------------------
package gmd_pkg;

  // field widths
  localparam int unsigned GradW  = 11;
  localparam int unsigned AbsW   = 11;
  localparam int unsigned SqW    = 2 * AbsW - 1;   // 1024^2 fits in 21 bits
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned RadW   = 16;             // radicand below saturation
  localparam int unsigned MagW   = 8;
  localparam int unsigned DirW   = 2;
  localparam int unsigned RemW   = MagW + 2;       // partial remainder
  localparam int unsigned SqrtNs = 4;              // root stages, two bits each

  // direction codes
  localparam logic [DirW-1:0] Dir0   = 2'd0;
  localparam logic [DirW-1:0] Dir45  = 2'd1;
  localparam logic [DirW-1:0] Dir90  = 2'd2;
  localparam logic [DirW-1:0] Dir135 = 2'd3;

  // payload carried alongside the root computation
  typedef struct packed {
    logic [DirW-1:0] dir;
    logic            sat;
  } side_t;

  // partial root state
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MagW-1:0] root;
  } root_t;

  // one restoring digit step: bring down two radicand bits, try root*4+1
  function automatic root_t sqrt_step(root_t cur, logic [1:0] pair);
    logic [RemW+1:0] tmp;
    logic [RemW+1:0] trial;
    root_t           nxt;
    tmp   = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (tmp >= trial) begin
      nxt.rem  = RemW'(tmp - trial);
      nxt.root = {cur.root[MagW-2:0], 1'b1};
    end else begin
      nxt.rem  = tmp[RemW-1:0];
      nxt.root = {cur.root[MagW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gmd_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmd_isqrt: pipelined 16-bit integer square root
// Four register stages, each resolving two root bits with a restoring digit
// step. Valid bits travel with the data; each stage holds when it is full and
// the stage after it cannot take its word.
// ----------------------------------------------------------------------------
module gmd_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [gmd_pkg::RadW-1:0]    rad_i,
  input  wire gmd_pkg::side_t              side_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [gmd_pkg::MagW-1:0]         root_o,
  output gmd_pkg::side_t                   side_o
);

  localparam int unsigned Ns = gmd_pkg::SqrtNs;

  logic [Ns-1:0]             vld_q;
  logic [Ns-1:0]             en;
  gmd_pkg::root_t            st_q   [Ns];
  logic [gmd_pkg::RadW-1:0]  rad_q  [Ns];
  gmd_pkg::side_t            side_q [Ns];

  // stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    en[Ns-1] = !vld_q[Ns-1] || ready_i;
    for (int i = Ns - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign ready_o = en[0];

  for (genvar g = 0; g < Ns; g++) begin : g_stage
    gmd_pkg::root_t            st_in;
    logic [gmd_pkg::RadW-1:0]  rad_in;
    gmd_pkg::side_t            side_in;
    logic                      vld_in;
    gmd_pkg::root_t            mid;
    gmd_pkg::root_t            st_d;

    if (g == 0) begin : g_first
      assign st_in   = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign st_in   = st_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // two digit steps on the top radicand bits
    always_comb begin
      mid  = gmd_pkg::sqrt_step(st_in, rad_in[gmd_pkg::RadW-1 -: 2]);
      st_d = gmd_pkg::sqrt_step(mid, rad_in[gmd_pkg::RadW-3 -: 2]);
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en[g]) begin
        vld_q[g] <= vld_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        st_q[g]   <= st_d;
        rad_q[g]  <= {rad_in[gmd_pkg::RadW-5:0], 4'b0000};
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Ns-1];
  assign root_o  = st_q[Ns-1].root;
  assign side_o  = side_q[Ns-1];

endmodule

`default_nettype wire

// ----- sv/gradient_magnitude_direction.sv -----
`default_nettype none
// Takes one signed gradient pair per word and returns floor(sqrt(x^2 + y^2))
// saturated at 255 together with a two-bit edge direction (0, 45, 90 or 135
// degrees). One word is accepted every clock cycle when the output side keeps
// up. There are seven register stages: one for absolute values and direction,
// one for the two squares, one for the sum and saturation check, and four
// stages of the square root pipeline, each resolving two root bits. Every
// stage has its own valid bit and holds only while full and blocked, so
// bubbles are squeezed out under back pressure.
// ----------------------------------------------------------------------------
// gradient_magnitude_direction: gradient magnitude and quantized direction
// Stream in, stream out; fully pipelined, one word per cycle while the output keeps up.
// ----------------------------------------------------------------------------
module gradient_magnitude_direction (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [10:0] grad_x, [21:11] grad_y, [23:22] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] magnitude, [9:8] direction, [15:10] zero
);

  localparam int unsigned GradW = gmd_pkg::GradW;
  localparam int unsigned AbsW  = gmd_pkg::AbsW;
  localparam int unsigned SqW   = gmd_pkg::SqW;
  localparam int unsigned SumW  = gmd_pkg::SumW;
  localparam int unsigned RadW  = gmd_pkg::RadW;
  localparam int unsigned MagW  = gmd_pkg::MagW;

  logic signed [GradW-1:0] grad_x;
  logic signed [GradW-1:0] grad_y;

  assign grad_x = s_axis_tdata[GradW-1:0];
  assign grad_y = s_axis_tdata[2*GradW-1:GradW];

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic sq_ready;

  // stage enables
  assign en3           = !v3_q || sq_ready;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;

  // ---- stage 1: absolute values and direction
  logic [AbsW-1:0]           ax, ay;
  logic [AbsW:0]             ax2, ay2;
  logic [gmd_pkg::DirW-1:0]  dir_d;
  logic [AbsW-1:0]           ax_q, ay_q;
  logic [gmd_pkg::DirW-1:0]  dir1_q;

  always_comb begin
    ax  = grad_x[GradW-1] ? AbsW'(-grad_x) : AbsW'(grad_x);
    ay  = grad_y[GradW-1] ? AbsW'(-grad_y) : AbsW'(grad_y);
    ax2 = {ax, 1'b0};
    ay2 = {ay, 1'b0};
    // zero x points along 0 degrees, whatever the value of y
    if (grad_x == '0) begin
      dir_d = gmd_pkg::Dir0;
    end else if ({1'b0, ay} > ax2) begin
      dir_d = gmd_pkg::Dir0;
    end else if ({1'b0, ax} > ay2) begin
      dir_d = gmd_pkg::Dir90;
    end else if (grad_x[GradW-1]) begin
      dir_d = gmd_pkg::Dir135;
    end else begin
      dir_d = gmd_pkg::Dir45;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ax_q   <= ax;
      ay_q   <= ay;
      dir1_q <= dir_d;
    end
  end

  // ---- stage 2: squares
  logic [SqW-1:0]            xx_q, yy_q;
  logic [gmd_pkg::DirW-1:0]  dir2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      xx_q   <= SqW'(ax_q * ax_q);
      yy_q   <= SqW'(ay_q * ay_q);
      dir2_q <= dir1_q;
    end
  end

  // ---- stage 3: sum of squares and saturation check
  logic [SumW-1:0]           sum;
  logic [RadW-1:0]           rad_q;
  gmd_pkg::side_t            side3_q;

  assign sum = {1'b0, xx_q} + {1'b0, yy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      rad_q       <= sum[RadW-1:0];
      side3_q.sat <= |sum[SumW-1:RadW];
      side3_q.dir <= dir2_q;
    end
  end

  // ---- stages 4..7: square root
  logic [MagW-1:0]  root;
  gmd_pkg::side_t   side_out;

  gmd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (sq_ready),
    .rad_i   (rad_q),
    .side_i  (side3_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .root_o  (root),
    .side_o  (side_out)
  );

  // output word
  assign m_axis_tdata = {6'b000000, side_out.dir, side_out.sat ? {MagW{1'b1}} : root};

endmodule

`default_nettype wire
